// ===== sv/shabs_pkg.sv =====
`default_nettype none

package shabs_pkg;

   // Request kinds.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Block fill positions and pad byte for padding; last digest word and round.
   localparam logic [5:0] LEN_FILL  = 6'd56;
   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [2:0] LAST_WORD = 3'd7;
   localparam logic [5:0] LAST_ROUND = 6'd63;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // Where the byte pushed into the block comes from.
   typedef enum logic [1:0] {
      BSRC_DATA,
      BSRC_PAD,
      BSRC_ZERO,
      BSRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic         push;
      byte_src_type src;
      logic         count;
      logic         load_vars;
      logic         round;
      logic         fold;
      logic         restart;
      logic [2:0]   word_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
   } dp_sts_type;

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

endpackage

`default_nettype wire

// ===== sv/shabs_dp.sv =====
`default_nettype none

module shabs_dp
   import shabs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   input  wire logic [7:0]  data_byte,
   output dp_sts_type       sts,
   output logic [31:0]      digest_word
);

   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic [5:0]  round_ff, round_in;
   logic [23:0] acc_ff, acc_in;
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] var_ff [8];
   logic [31:0] var_in [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];

   logic [63:0] len_shift;
   logic [7:0]  byte_in;
   logic [31:0] sched_w;
   logic [31:0] t1;
   logic [31:0] t2;

   // The message bit length, taken most significant byte first.
   assign len_shift = {total_ff, 3'b000} << {fill_ff[2:0], 3'b000};

   always_comb begin
      case (cmd.src)
         BSRC_DATA: byte_in = data_byte;
         BSRC_PAD:  byte_in = PAD_BYTE;
         BSRC_ZERO: byte_in = 8'h00;
         BSRC_LEN:  byte_in = len_shift[63:56];
         default:   byte_in = 8'h00;
      endcase
   end

   // Schedule word for sixteen rounds ahead, from the rolling window.
   assign sched_w = ssig1(win_ff[14]) + win_ff[9] + ssig0(win_ff[1]) + win_ff[0];

   assign t1 = var_ff[7] + bsig1(var_ff[4])
             + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
             + ROUND_K[round_ff] + win_ff[0];
   assign t2 = bsig0(var_ff[0])
             + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2])
                ^ (var_ff[1] & var_ff[2]));

   always_comb begin
      fill_in  = fill_ff;
      total_in = total_ff;
      round_in = round_ff;
      acc_in   = acc_ff;
      win_in   = win_ff;
      var_in   = var_ff;
      chain_in = chain_ff;
      if (cmd.push) begin
         acc_in  = {acc_ff[15:0], byte_in};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = {acc_ff, byte_in};
         end
      end
      if (cmd.count) begin
         total_in = total_ff + 61'd1;
      end
      if (cmd.load_vars) begin
         var_in   = chain_ff;
         round_in = 6'd0;
      end
      if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = sched_w;
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = var_ff[4];
         var_in[4] = var_ff[3] + t1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = var_ff[0];
         var_in[0] = t1 + t2;
         round_in  = round_ff + 6'd1;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + var_ff[i];
         end
      end
      if (cmd.restart) begin
         chain_in = INIT_H;
         total_in = 61'd0;
         fill_in  = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= 6'd0;
         total_ff <= 61'd0;
         round_ff <= 6'd0;
         chain_ff <= INIT_H;
      end else begin
         fill_ff  <= fill_in;
         total_ff <= total_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
      acc_ff <= acc_in;
      win_ff <= win_in;
      var_ff <= var_in;
   end

   assign sts.fill       = fill_ff;
   assign sts.round_last = (round_ff == LAST_ROUND);
   assign digest_word    = chain_ff[cmd.word_sel];

endmodule

`default_nettype wire

// ===== sv/shabs_ctrl.sv =====
`default_nettype none

module shabs_ctrl
   import shabs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last,
   input  wire dp_sts_type  sts,
   output dp_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic       pad_ff, pad_in;       // message ended, padding under way
   logic       len_ff, len_in;       // length bytes being written
   logic       final_ff, final_in;   // block in flight is the last one
   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      pad_in   = pad_ff;
      len_in   = len_ff;
      final_in = final_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.src      = BSRC_DATA;
      cmd.word_sel = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.push = 1'b1;
               if (req_kind == KIND_END) begin
                  cmd.src  = BSRC_PAD;
                  pad_in   = 1'b1;
                  state_in = ST_PAD;
               end else begin
                  cmd.count = 1'b1;
               end
               if (sts.fill == LAST_FILL) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            if (len_ff || sts.fill == LEN_FILL) begin
               cmd.src = BSRC_LEN;
               len_in  = 1'b1;
            end else begin
               cmd.src = BSRC_ZERO;
            end
            if (sts.fill == LAST_FILL) begin
               final_in = len_in;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_vars = 1'b1;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (sts.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (final_ff) begin
               valid_in = 1'b1;
               idx_in   = 3'd0;
               state_in = ST_EMIT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (idx_ff == LAST_WORD) begin
                  cmd.restart = 1'b1;
                  valid_in    = 1'b0;
                  pad_in      = 1'b0;
                  len_in      = 1'b0;
                  final_in    = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pad_ff   <= 1'b0;
         len_ff   <= 1'b0;
         final_ff <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         pad_ff   <= pad_in;
         len_ff   <= len_in;
         final_ff <= final_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_word_index = idx_ff;
   assign rsp_last       = (idx_ff == LAST_WORD);

   a_valid_in_emit: assert property (@(posedge clock) disable iff (reset)
      valid_ff == (state_ff == ST_EMIT))
      else $error("result valid out of step with the emit state");

   a_round_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> $past(state_ff) == ST_ROUND || $past(state_ff) == ST_LOAD)
      else $error("rounds entered without loading the working variables");

   a_emit_block_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> sts.fill == 6'd0)
      else $error("digest emitted with a partly filled block");

   a_final_has_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD && final_ff) |-> len_ff && pad_ff)
      else $error("final block folded without the length field");

endmodule

`default_nettype wire

// ===== sv/sha256_byte_stream_hasher_top.sv =====
// SHA-256 byte stream hasher.
// The request channel (req_valid, req_stall, req_kind, req_data_byte) takes
// one item per message byte with req_kind low, and one end-of-message item
// with req_kind high; req_data_byte is ignored on the end item.
// The response channel (rsp_valid, rsp_stall, rsp_digest_word,
// rsp_word_index, rsp_last) returns the eight digest words of each message,
// word 0 first, with rsp_last set on word 7. Empty messages are hashed too.
// The byte that completes a 64-byte block starts a compression, during which
// req_stall is high: the working variables are loaded, 64 rounds pass
// through the single round unit, and the result is folded into the chaining
// value. No new byte is taken until that fold is done.
// After the end item the block pads itself one byte per cycle (up to 64
// bytes, or up to 72 when the length no longer fits) with a compression
// after each full block, then offers the digest words once the last block
// is folded. A stalled receiver simply holds the current word; nothing else
// moves until it is taken.
// Synchronous reset returns the chaining value to the initial hash and
// clears the byte counters; no clearing pass is needed.
`default_nettype none

module sha256_byte_stream_hasher_top
   import shabs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last
);

   // Commands from the controller to the datapath, and status back.
   dp_cmd_type cmd;
   dp_sts_type sts;

   // The controller sequences byte pushes, padding, rounds and the digest
   // read-out; it also owns both handshakes.
   shabs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last),
      .sts            (sts),
      .cmd            (cmd)
   );

   // The datapath holds the block as a sixteen-word schedule window, the
   // working variables, the chaining value and the byte counters.
   shabs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .sts         (sts),
      .digest_word (rsp_digest_word)
   );

endmodule

`default_nettype wire
